// ===== rtl/spq_pkg.sv =====
// Shared types and codes for the sorted priority queue.
package spq_pkg;

	localparam logic KIND_ENQ = 1'b0;
	localparam logic KIND_DEQ = 1'b1;

	typedef struct packed {
		logic enq;
		logic deq;
	} cmd_t;

endpackage

// ===== rtl/spq_req_if.sv =====
// Request channel carrying one queue operation per item.
interface spq_req_if #(
	parameter int ELEMENT_BITS  = 16,
	parameter int PRIORITY_BITS = 8
) ();
	logic                     valid;
	logic                     ready;
	logic                     kind;
	logic [ELEMENT_BITS-1:0]  element;
	logic [PRIORITY_BITS-1:0] priority_req;

	modport source (output valid, output kind, output element, output priority_req,
		input ready);
	modport sink (input valid, input kind, input element, input priority_req,
		output ready);
endinterface

// ===== rtl/spq_rsp_if.sv =====
// Response channel carrying one operation result per item.
interface spq_rsp_if #(
	parameter int ELEMENT_BITS = 16,
	parameter int COUNT_BITS   = 5
) ();
	logic                    valid;
	logic                    ready;
	logic                    success;
	logic [ELEMENT_BITS-1:0] removed_element;
	logic [COUNT_BITS-1:0]   entry_count;
	logic                    is_empty;

	modport source (output valid, output success, output removed_element,
		output entry_count, output is_empty, input ready);
	modport sink (input valid, input success, input removed_element,
		input entry_count, input is_empty, output ready);
endinterface

// ===== rtl/spq_cell.sv =====
// One slot of the sorted chain: holds an entry and shifts it toward either neighbor.
module spq_cell #(
	parameter int ELEMENT_BITS  = 16,
	parameter int PRIORITY_BITS = 8
) (
	input  logic                     clk,
	input  spq_pkg::cmd_t            cmd,
	input  logic                     occupied,
	input  logic [ELEMENT_BITS-1:0]  new_elem,
	input  logic [PRIORITY_BITS-1:0] new_prio,
	input  logic                     left_keep,
	input  logic [ELEMENT_BITS-1:0]  left_elem,
	input  logic [PRIORITY_BITS-1:0] left_prio,
	input  logic [ELEMENT_BITS-1:0]  right_elem,
	input  logic [PRIORITY_BITS-1:0] right_prio,
	output logic                     keep,
	output logic [ELEMENT_BITS-1:0]  elem,
	output logic [PRIORITY_BITS-1:0] prio
);
	import spq_pkg::*;

	logic [ELEMENT_BITS-1:0]  elem_q;
	logic [PRIORITY_BITS-1:0] prio_q;

	// A stored entry stays put only if it outranks the newcomer strictly.
	assign keep = occupied && (new_prio < prio_q);
	assign elem = elem_q;
	assign prio = prio_q;

	always_ff @(posedge clk) begin
		if (cmd.enq && !keep) begin
			if (left_keep) begin
				elem_q <= new_elem;
				prio_q <= new_prio;
			end else begin
				elem_q <= left_elem;
				prio_q <= left_prio;
			end
		end else if (cmd.deq) begin
			elem_q <= right_elem;
			prio_q <= right_prio;
		end
	end

endmodule

// ===== rtl/sorted_priority_queue.sv =====
// Sorted priority queue built as a chain of CAPACITY cells, highest priority at cell zero.
// An item is accepted in every cycle the result register is free or being drained, and its
// result is registered and appears in the following cycle; throughput is one item per
// cycle while results are drained. Every cell compares the incoming priority against its
// own entry in the same cycle and then holds, takes the new entry or takes its neighbor's
// entry. Equal priorities leave newest first. No clearing pass is needed after reset.
module sorted_priority_queue #(
	parameter int CAPACITY      = 16,
	parameter int ELEMENT_BITS  = 16,
	parameter int PRIORITY_BITS = 8
) (
	input logic clk,
	input logic arst_n,
	spq_req_if.sink   req,
	spq_rsp_if.source rsp
);
	import spq_pkg::*;

	localparam int COUNT_BITS = $clog2(CAPACITY + 1);

	logic [COUNT_BITS-1:0]    count_q;
	logic                     rsp_valid_q;
	logic                     rsp_success_q;
	logic [ELEMENT_BITS-1:0]  rsp_elem_q;
	logic [COUNT_BITS-1:0]    rsp_count_q;
	logic                     rsp_empty_q;

	logic                     accept;
	logic                     full;
	logic                     empty;
	cmd_t                     cmd;
	logic [COUNT_BITS-1:0]    count_next;

	logic [CAPACITY-1:0]      keep_w;
	logic [ELEMENT_BITS-1:0]  elem_w [CAPACITY];
	logic [PRIORITY_BITS-1:0] prio_w [CAPACITY];

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;
	assign full      = (count_q == COUNT_BITS'(CAPACITY));
	assign empty     = (count_q == '0);
	assign cmd.enq   = accept && (req.kind == KIND_ENQ) && !full;
	assign cmd.deq   = accept && (req.kind == KIND_DEQ) && !empty;

	always_comb begin
		count_next = count_q;
		if (cmd.enq) begin
			count_next = count_q + 1'b1;
		end else if (cmd.deq) begin
			count_next = count_q - 1'b1;
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic                     left_keep;
		logic [ELEMENT_BITS-1:0]  left_elem;
		logic [PRIORITY_BITS-1:0] left_prio;
		logic [ELEMENT_BITS-1:0]  right_elem;
		logic [PRIORITY_BITS-1:0] right_prio;

		if (i == 0) begin : g_head
			assign left_keep = 1'b1;
			assign left_elem = '0;
			assign left_prio = '0;
		end else begin : g_mid
			assign left_keep = keep_w[i-1];
			assign left_elem = elem_w[i-1];
			assign left_prio = prio_w[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign right_elem = elem_w[i];
			assign right_prio = prio_w[i];
		end else begin : g_body
			assign right_elem = elem_w[i+1];
			assign right_prio = prio_w[i+1];
		end

		spq_cell #(
			.ELEMENT_BITS (ELEMENT_BITS),
			.PRIORITY_BITS(PRIORITY_BITS)
		) u_cell (
			.clk       (clk),
			.cmd       (cmd),
			.occupied  (COUNT_BITS'(i) < count_q),
			.new_elem  (req.element),
			.new_prio  (req.priority_req),
			.left_keep (left_keep),
			.left_elem (left_elem),
			.left_prio (left_prio),
			.right_elem(right_elem),
			.right_prio(right_prio),
			.keep      (keep_w[i]),
			.elem      (elem_w[i]),
			.prio      (prio_w[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			count_q <= count_next;
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_success_q <= cmd.enq || cmd.deq;
			rsp_elem_q    <= cmd.deq ? elem_w[0] : '0;
			rsp_count_q   <= count_next;
			rsp_empty_q   <= (count_next == '0);
		end
	end

	assign rsp.valid           = rsp_valid_q;
	assign rsp.success         = rsp_success_q;
	assign rsp.removed_element = rsp_elem_q;
	assign rsp.entry_count     = rsp_count_q;
	assign rsp.is_empty        = rsp_empty_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_BITS'(CAPACITY))
		else $error("entry count exceeds capacity");

	a_enq_grows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.enq |=> (count_q == $past(count_q) + 1'b1))
		else $error("successful enqueue did not grow the queue");

	a_head_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q >= COUNT_BITS'(2)) |-> (prio_w[0] >= prio_w[1]))
		else $error("head entry is outranked by the next entry");

	a_fail_no_elem: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && !rsp_success_q) |-> (rsp_elem_q == '0))
		else $error("failed operation returned an element");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> (rsp_empty_q == (rsp_count_q == '0)))
		else $error("empty flag disagrees with entry count");
`endif

endmodule

// ===== sim/tb_sorted_priority_queue.sv =====
// Self-checking testbench for the sorted priority queue with a predicting scoreboard.
`timescale 1ns / 1ps

module tb_sorted_priority_queue;
	import spq_pkg::*;

	localparam int CAPACITY      = 16;
	localparam int ELEMENT_BITS  = 16;
	localparam int PRIORITY_BITS = 8;
	localparam int COUNT_BITS    = 5;
	localparam int PHASE_ITEMS   = 360;
	localparam int LONG_HOLD     = 80;

	typedef struct packed {
		logic                    success;
		logic [ELEMENT_BITS-1:0] removed_element;
		logic [COUNT_BITS-1:0]   entry_count;
		logic                    is_empty;
	} queue_result_t;

	class queue_scoreboard;
		logic [ELEMENT_BITS-1:0]  elem_slots[CAPACITY];
		logic [PRIORITY_BITS-1:0] prio_slots[CAPACITY];
		int unsigned              stored;
		queue_result_t            expected_results[$];
		int                       mismatches;

		function new();
			stored     = 0;
			mismatches = 0;
		endfunction

		// Applies one accepted operation to the shadow queue and keeps its outcome.
		function void note_operation(logic kind, logic [ELEMENT_BITS-1:0] elem,
			logic [PRIORITY_BITS-1:0] prio);
			queue_result_t r;
			int unsigned   pos;
			int unsigned   i;
			r = '0;
			if (kind == KIND_ENQ) begin
				if (stored < CAPACITY) begin
					// The new entry goes ahead of the first entry that does not outrank it.
					pos = 0;
					while (pos < stored && prio < prio_slots[pos])
						pos++;
					for (i = stored; i > pos; i--) begin
						elem_slots[i] = elem_slots[i-1];
						prio_slots[i] = prio_slots[i-1];
					end
					elem_slots[pos] = elem;
					prio_slots[pos] = prio;
					stored++;
					r.success = 1'b1;
				end
			end else if (stored != 0) begin
				r.removed_element = elem_slots[0];
				for (i = 1; i < stored; i++) begin
					elem_slots[i-1] = elem_slots[i];
					prio_slots[i-1] = prio_slots[i];
				end
				stored--;
				r.success = 1'b1;
			end
			r.entry_count = stored[COUNT_BITS-1:0];
			r.is_empty    = (stored == 0);
			expected_results.push_back(r);
		endfunction

		task report_mismatch(string msg);
			$display("%0t ns: mismatch: %s", $time, msg);
			mismatches++;
		endtask

		task check_result(queue_result_t got);
			queue_result_t want;
			if (expected_results.size() == 0) begin
				report_mismatch("result arrived with no operation outstanding");
				return;
			end
			want = expected_results.pop_front();
			if (got.success !== want.success)
				report_mismatch($sformatf("success got %b, expected %b",
					got.success, want.success));
			if (got.removed_element !== want.removed_element)
				report_mismatch($sformatf("removed_element got %h, expected %h",
					got.removed_element, want.removed_element));
			if (got.entry_count !== want.entry_count)
				report_mismatch($sformatf("entry_count got %0d, expected %0d",
					got.entry_count, want.entry_count));
			if (got.is_empty !== want.is_empty)
				report_mismatch($sformatf("is_empty got %b, expected %b",
					got.is_empty, want.is_empty));
		endtask
	endclass

	logic clk;
	logic arst_n;

	spq_req_if #(.ELEMENT_BITS(ELEMENT_BITS), .PRIORITY_BITS(PRIORITY_BITS)) req ();
	spq_rsp_if #(.ELEMENT_BITS(ELEMENT_BITS), .COUNT_BITS(COUNT_BITS)) rsp ();

	sorted_priority_queue #(
		.CAPACITY     (CAPACITY),
		.ELEMENT_BITS (ELEMENT_BITS),
		.PRIORITY_BITS(PRIORITY_BITS)
	) u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.rsp   (rsp)
	);

	queue_scoreboard queue_sb;
	int              send_idle_pct;
	int              recv_idle_pct;
	int              hold_left;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("*** FAILED ***");
		$finish;
	end

	// Result side: random back-pressure, plus a long hold-off when one is requested.
	initial begin
		rsp.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				rsp.ready <= 1'b0;
				hold_left--;
			end else begin
				rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready)
			queue_sb.check_result({rsp.success, rsp.removed_element, rsp.entry_count,
				rsp.is_empty});
	end

	task automatic send_op(logic kind, logic [ELEMENT_BITS-1:0] elem,
		logic [PRIORITY_BITS-1:0] prio);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			req.valid <= 1'b0;
			@(negedge clk);
		end
		req.valid        <= 1'b1;
		req.kind         <= kind;
		req.element      <= elem;
		req.priority_req <= prio;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		queue_sb.note_operation(kind, elem, prio);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		req.valid <= 1'b0;
		while (queue_sb.expected_results.size() != 0)
			@(posedge clk);
	endtask

	// Bursts lean toward enqueues or dequeues, or are balanced, so the queue keeps running full and empty.
	task automatic run_random(int n_items);
		int   enq_pct;
		int   burst_left;
		logic kind;
		logic [PRIORITY_BITS-1:0] prio;
		burst_left = 0;
		enq_pct    = 50;
		for (int n = 0; n < n_items; n++) begin
			if (burst_left == 0) begin
				case ($urandom_range(2))
					0: enq_pct = 85;
					1: enq_pct = 15;
					default: enq_pct = 50;
				endcase
				burst_left = $urandom_range(40, 5);
			end
			burst_left--;
			kind = ($urandom_range(99) < enq_pct) ? KIND_ENQ : KIND_DEQ;
			// A narrow priority range makes ties common.
			if ($urandom_range(99) < 30)
				prio = PRIORITY_BITS'($urandom_range(3));
			else
				prio = PRIORITY_BITS'($urandom_range(255));
			send_op(kind, ELEMENT_BITS'($urandom_range(65535)), prio);
		end
	endtask

	initial begin
		queue_sb         = new();
		send_idle_pct    = 0;
		recv_idle_pct    = 0;
		hold_left        = 0;
		arst_n           = 1'b0;
		req.valid        = 1'b0;
		req.kind         = KIND_ENQ;
		req.element      = '0;
		req.priority_req = '0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		send_op(KIND_DEQ, 16'hFFFF, 8'hFF);
		send_op(KIND_ENQ, 16'hFFFF, 8'hFF);
		send_op(KIND_ENQ, 16'h0000, 8'h00);
		send_op(KIND_ENQ, 16'h1234, 8'h80);
		send_op(KIND_ENQ, 16'hABCD, 8'h80);
		send_op(KIND_ENQ, 16'h5555, 8'hFF);
		send_op(KIND_ENQ, 16'h00FF, 8'h7F);
		send_op(KIND_ENQ, 16'hA5A5, 8'h00);
		for (int n = 0; n < 8; n++)
			send_op(KIND_DEQ, 16'h0000, 8'h00);
		send_op(KIND_DEQ, 16'h0000, 8'h00);
		wait_drained();

		send_idle_pct = 11;
		recv_idle_pct = 65;
		hold_left     = LONG_HOLD;
		run_random(PHASE_ITEMS);
		wait_drained();

		send_idle_pct = 65;
		recv_idle_pct = 11;
		run_random(PHASE_ITEMS);
		wait_drained();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_random(PHASE_ITEMS);
		wait_drained();

		repeat (20) @(posedge clk);
		if (queue_sb.mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== sorted_priority_queue.f =====
rtl/spq_pkg.sv
rtl/spq_req_if.sv
rtl/spq_rsp_if.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue.sv
sim/tb_sorted_priority_queue.sv
